// ===== src/rtsc_pkg.sv =====
// shared types and constants for the refcounted tile slot cache
`timescale 1ns / 1ps

package rtsc_pkg;

	localparam logic [15:0] CEILING_RESET = 16'h0300;
	localparam int REF_W = 8;
	localparam logic [REF_W-1:0] COUNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_BLANK   = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  icon_id;
		logic [15:0] palette_base;
	} req_t;

	typedef struct packed {
		logic [15:0] tile_top_left;
		logic [15:0] tile_top_right;
		logic [15:0] tile_bottom_left;
		logic [15:0] tile_bottom_right;
		logic        hit;
		logic        needs_load;
		logic        alloc_failed;
		logic [5:0]  slot_number;
		logic [7:0]  reference_count;
		logic [5:0]  slots_used;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic sweep_step;
	} cmd_t;

	typedef struct packed {
		logic clear_op;
		logic out_free;
		logic sweep_last;
	} sts_t;

endpackage

// ===== src/rtsc_ctrl.sv =====
// controller state machine: table sweep, request accept and execute sequencing
`timescale 1ns / 1ps

module rtsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rtsc_pkg::sts_t sts,
	output rtsc_pkg::cmd_t cmd
);

	rtsc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtsc_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		cmd = '0;
		case (state_q)
			rtsc_pkg::ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = rtsc_pkg::ST_IDLE;
				end
			end
			rtsc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d = rtsc_pkg::ST_EXEC;
				end
			end
			rtsc_pkg::ST_EXEC: begin
				// hold here until the output register can take the result
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d = sts.clear_op ? rtsc_pkg::ST_SWEEP : rtsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rtsc_pkg::ST_SWEEP;
			end
		endcase
	end

endmodule

// ===== src/rtsc_datapath.sv =====
// datapath: entry table memory, slot pool, tile arithmetic and output register
`timescale 1ns / 1ps

module rtsc_datapath #(
	parameter int ICON_COUNT = 224,
	parameter int SLOT_COUNT = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rtsc_pkg::req_t  req_data,
	input  logic           cfg_valid,
	input  logic [15:0]    cfg_data,
	output rtsc_pkg::rsp_t  rsp_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  rtsc_pkg::cmd_t  cmd,
	output rtsc_pkg::sts_t  sts
);

	localparam int IW = (ICON_COUNT > 1) ? $clog2(ICON_COUNT) : 1;
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int EW = CW + rtsc_pkg::REF_W;

	logic [EW-1:0] mem [ICON_COUNT];

	logic [1:0]            op_q;
	logic                  in_range_q;
	logic [15:0]           pal_q;
	logic [IW-1:0]         addr_q;
	logic [EW-1:0]         rd_q;
	logic [15:0]           ceil_q;
	logic [SLOT_COUNT-1:0] occ_q;
	logic [CW-1:0]         used_q;
	logic [IW-1:0]         sweep_q;
	rtsc_pkg::rsp_t         rsp_q;
	logic                  rsp_valid_q;

	logic                  req_in_range;
	logic [IW-1:0]         req_addr;
	logic [CW-1:0]         e_code;
	logic [7:0]            e_refs;
	logic [7:0]            bumped;
	logic [SW-1:0]         ff;
	logic                  free_any;
	logic [CW-1:0]         new_code;
	logic [15:0]           base;
	logic [SLOT_COUNT-1:0] occ_d;
	logic [CW-1:0]         used_d;
	logic                  wr_exec;
	logic [EW-1:0]         wr_exec_data;
	rtsc_pkg::rsp_t         rsp_d;

	assign req_in_range = {24'd0, req_data.icon_id} < 32'(ICON_COUNT);
	assign req_addr = req_in_range ? IW'(req_data.icon_id) : '0;
	assign e_code = rd_q[EW-1 -: CW];
	assign e_refs = rd_q[rtsc_pkg::REF_W-1:0];
	assign bumped = (e_refs == rtsc_pkg::COUNT_MAX) ? e_refs : e_refs + 8'd1;

	// lowest free slot
	always_comb begin
		ff = '0;
		free_any = 1'b0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			if (!occ_q[k]) begin
				ff = SW'(k);
				free_any = 1'b1;
			end
		end
	end

	always_comb begin
		occ_d = occ_q;
		used_d = used_q;
		wr_exec = 1'b0;
		wr_exec_data = '0;
		new_code = '0;
		rsp_d = '0;
		case (op_q)
			rtsc_pkg::OP_ACQUIRE: begin
				if (in_range_q) begin
					if (e_code != '0) begin
						new_code = e_code;
						rsp_d.hit = 1'b1;
					end else if (free_any) begin
						new_code = CW'(ff) + CW'(1);
						occ_d[ff] = 1'b1;
						used_d = used_q + CW'(1);
						rsp_d.needs_load = 1'b1;
					end else begin
						rsp_d.alloc_failed = 1'b1;
					end
					wr_exec = 1'b1;
					wr_exec_data = {new_code, bumped};
					rsp_d.slot_number = 6'(new_code);
					rsp_d.reference_count = bumped;
					rsp_d.tile_top_left = base;
					rsp_d.tile_top_right = base + 16'd1;
					rsp_d.tile_bottom_left = base + 16'd2;
					rsp_d.tile_bottom_right = base + 16'd3;
				end
			end
			rtsc_pkg::OP_RELEASE: begin
				if (in_range_q) begin
					if (e_code != '0) begin
						occ_d[SW'(e_code - CW'(1))] = 1'b0;
						used_d = used_q - CW'(1);
						wr_exec = 1'b1;
						wr_exec_data = {{CW{1'b0}}, e_refs};
					end
					rsp_d.reference_count = e_refs;
				end
			end
			rtsc_pkg::OP_CLEAR: begin
				occ_d = '0;
				used_d = '0;
			end
			default: begin
			end
		endcase
		rsp_d.slots_used = 6'(used_d);
	end

	// slot code c sits 4*c tiles below the ceiling
	assign base = ceil_q - 16'({new_code, 2'b00}) + pal_q;

	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			mem[sweep_q] <= '0;
		end else if (cmd.exec && wr_exec) begin
			mem[addr_q] <= wr_exec_data;
		end
		if (cmd.accept) begin
			rd_q <= mem[req_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= req_data.operation;
			in_range_q <= req_in_range;
			pal_q <= req_data.palette_base;
			addr_q <= req_addr;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q <= rtsc_pkg::CEILING_RESET;
			occ_q <= '0;
			used_q <= '0;
			sweep_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ceil_q <= cfg_data;
			end
			if (cmd.exec) begin
				occ_q <= occ_d;
				used_q <= used_d;
			end
			if (cmd.sweep_step) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + IW'(1);
			end
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_op = (op_q == rtsc_pkg::OP_CLEAR);
	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign sts.sweep_last = (sweep_q == IW'(ICON_COUNT - 1));

	assign rsp_data = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== src/refcounted_tile_slot_cache_core.sv =====
// top level of the refcounted tile slot cache
`timescale 1ns / 1ps

// Maps icon ids onto a pool of SLOT_COUNT four-tile slots with 8-bit reference
// counts. A request on req_* (valid/ready) carries an operation (acquire, release,
// blank, clear all), an icon id and a palette base; each request produces exactly
// one result on rsp_* (valid/ready) with the four tile words, hit / needs_load /
// alloc_failed flags, slot code, reference count and slots in use.
// cfg_* writes the 16-bit tile ceiling; cfg_ready is always high, and writes are
// meant to happen while no request is in flight.
// Sequence: accepting a request reads the entry table (one memory, read
// registered); the execute step then does the read-modify-write and loads the
// result register. A new request is taken only after the current one has
// executed, since that memory read-modify-write sits between them.
// After reset, and after a clear-all request, the entry table is swept to zero one
// entry per cycle: req_ready stays low until the whole table is swept.
// The result register decouples the output: a new request is taken while a result
// waits; if the receiver still stalls when the next result is ready, the block
// holds that request in its execute step until the register frees up.
module refcounted_tile_slot_cache_core #(
	parameter int ICON_COUNT = 224,
	parameter int SLOT_COUNT = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rtsc_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rtsc_pkg::rsp_t rsp_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data
);

	rtsc_pkg::cmd_t cmd;
	rtsc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rtsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rtsc_datapath #(
		.ICON_COUNT (ICON_COUNT),
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp_data  (rsp_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== src/rtsc_checker.sv =====
// port-level checker for the refcounted tile slot cache, bound to the top level
`timescale 1ns / 1ps

module rtsc_checker #(
	parameter int SLOT_COUNT = 32
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input rtsc_pkg::rsp_t rsp_data
);

	// result stays put while the receiver stalls
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// one request at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted back to back");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $countones({rsp_data.hit, rsp_data.needs_load,
			rsp_data.alloc_failed}) <= 1)
		else $error("more than one acquire outcome flag");

	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.alloc_failed |-> rsp_data.slot_number == 6'd0)
		else $error("failed acquire reports a slot");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_data.slots_used) <= SLOT_COUNT)
		else $error("slots in use beyond pool size");

endmodule

bind refcounted_tile_slot_cache_core rtsc_checker #(
	.SLOT_COUNT (SLOT_COUNT)
) u_rtsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);

// ===== bench/tb.sv =====
// testbench for the refcounted tile slot cache core: predicts every result and checks it
`timescale 1ns / 1ps

module tb;

	localparam int ICONS = 224;
	localparam int SLOTS = 32;
	// a clear-all sweeps the whole entry table before the block takes requests again
	localparam int SETTLE_CYCLES = ICONS + 16;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   req_valid;
	logic   req_ready;
	rtsc_pkg::req_t req_data;
	logic   rsp_valid;
	logic   rsp_ready = 1'b0;
	rtsc_pkg::rsp_t rsp_data;
	logic   cfg_valid;
	logic   cfg_ready;
	logic [15:0] cfg_data;

	// predicted state of the cache
	logic [15:0] ceiling_model;
	logic [5:0]  slot_code_model [ICONS];
	logic [7:0]  ref_count_model [ICONS];
	logic        slot_busy_model [SLOTS];

	rtsc_pkg::rsp_t pending_tiles [$];
	int   mismatches;
	logic calm;
	int   stall_left = 0;

	refcounted_tile_slot_cache_core #(
		.ICON_COUNT(ICONS),
		.SLOT_COUNT(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_tables();
		foreach (slot_code_model[i]) slot_code_model[i] = '0;
		foreach (ref_count_model[i]) ref_count_model[i] = '0;
		foreach (slot_busy_model[i]) slot_busy_model[i] = 1'b0;
	endfunction

	function automatic rtsc_pkg::rsp_t predict_tiles(input rtsc_pkg::req_t item);
		rtsc_pkg::rsp_t res;
		logic [15:0] base;
		int free_slot;
		int icon;
		int used;
		res = '0;
		icon = int'(item.icon_id);
		case (rtsc_pkg::op_t'(item.operation))
			rtsc_pkg::OP_CLEAR: begin
				clear_tables();
			end
			rtsc_pkg::OP_ACQUIRE: begin
				if (icon < ICONS) begin
					if (slot_code_model[icon] != 0) begin
						res.hit = 1'b1;
					end else begin
						free_slot = -1;
						for (int k = 0; k < SLOTS; k++)
							if (!slot_busy_model[k] && free_slot < 0)
								free_slot = k;
						if (free_slot >= 0) begin
							slot_busy_model[free_slot] = 1'b1;
							slot_code_model[icon] = 6'(free_slot + 1);
							res.needs_load = 1'b1;
						end else begin
							res.alloc_failed = 1'b1;
						end
					end
					// count saturates on every acquire path
					if (ref_count_model[icon] != rtsc_pkg::COUNT_MAX)
						ref_count_model[icon] = ref_count_model[icon] + 8'd1;
					base = ceiling_model + item.palette_base - {slot_code_model[icon], 2'b00};
					res.tile_top_left = base;
					res.tile_top_right = base + 16'd1;
					res.tile_bottom_left = base + 16'd2;
					res.tile_bottom_right = base + 16'd3;
					res.slot_number = slot_code_model[icon];
					res.reference_count = ref_count_model[icon];
				end
			end
			rtsc_pkg::OP_RELEASE: begin
				if (icon < ICONS) begin
					if (slot_code_model[icon] != 0) begin
						slot_busy_model[5'(slot_code_model[icon] - 6'd1)] = 1'b0;
						slot_code_model[icon] = '0;
					end
					res.reference_count = ref_count_model[icon];
				end
			end
			default: ;
		endcase
		used = 0;
		foreach (slot_busy_model[k])
			if (slot_busy_model[k])
				used++;
		res.slots_used = 6'(used);
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_tiles(input rtsc_pkg::rsp_t got);
		rtsc_pkg::rsp_t want;
		if (pending_tiles.size() == 0) begin
			$display("%0t: unexpected result, expected none actual %0h", $time, got);
			mismatches++;
		end else begin
			want = pending_tiles.pop_front();
			compare_field("tile_top_left", want.tile_top_left, got.tile_top_left);
			compare_field("tile_top_right", want.tile_top_right, got.tile_top_right);
			compare_field("tile_bottom_left", want.tile_bottom_left, got.tile_bottom_left);
			compare_field("tile_bottom_right", want.tile_bottom_right, got.tile_bottom_right);
			compare_field("hit", 16'(want.hit), 16'(got.hit));
			compare_field("needs_load", 16'(want.needs_load), 16'(got.needs_load));
			compare_field("alloc_failed", 16'(want.alloc_failed), 16'(got.alloc_failed));
			compare_field("slot_number", 16'(want.slot_number), 16'(got.slot_number));
			compare_field("reference_count", 16'(want.reference_count),
				16'(got.reference_count));
			compare_field("slots_used", 16'(want.slots_used), 16'(got.slots_used));
		end
	endtask

	// result side: check each accepted result, stall the receiver in random bursts
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_tiles(rsp_data);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// valid stays high after a request, so back-to-back requests keep it up unless a random gap drops it
	task automatic send_request(input rtsc_pkg::op_t op, input logic [7:0] icon,
			input logic [15:0] pal);
		rtsc_pkg::req_t item;
		int gap;
		item.operation = op;
		item.icon_id = icon;
		item.palette_base = pal;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_tiles.push_back(predict_tiles(item));
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_tiles.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ceiling(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		ceiling_model = value;
	endtask

	// runs on the reset ceiling: field extremes, every operation, out-of-range ids
	task automatic test_basic_ops();
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd0, 16'h0000);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd0, 16'h0000);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd223, 16'hFFFF);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd224, 16'h1234);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd255, 16'hFFFF);
		send_request(rtsc_pkg::OP_RELEASE, 8'd255, 16'hFFFF);
		send_request(rtsc_pkg::OP_BLANK, 8'd255, 16'hFFFF);
		send_request(rtsc_pkg::OP_BLANK, 8'd5, 16'hA5A5);
		send_request(rtsc_pkg::OP_RELEASE, 8'd0, 16'h0000);
		send_request(rtsc_pkg::OP_RELEASE, 8'd0, 16'h0000);
		send_request(rtsc_pkg::OP_RELEASE, 8'd77, 16'h0000);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd170, 16'h5A5A);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd0, 16'h8000);
		send_request(rtsc_pkg::OP_CLEAR, 8'd255, 16'hFFFF);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd223, 16'h0001);
		send_request(rtsc_pkg::OP_RELEASE, 8'd223, 16'h0000);
		drain_results();
	endtask

	// ceiling 0: a base wraps below zero whenever the palette base is below four times the slot code
	task automatic test_pool_exhaustion();
		write_ceiling(16'h0000);
		send_request(rtsc_pkg::OP_CLEAR, 8'd0, 16'h0000);
		for (int i = 0; i < SLOTS; i++)
			send_request(rtsc_pkg::OP_ACQUIRE, 8'(10 + i), 16'($urandom_range(0, 16'hFFFF)));
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd60, 16'h0000);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd60, 16'h0004);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd20, 16'h0000);
		send_request(rtsc_pkg::OP_RELEASE, 8'd25, 16'h0000);
		send_request(rtsc_pkg::OP_RELEASE, 8'd12, 16'h0000);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd61, 16'h0000);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd60, 16'h0000);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd62, 16'h0000);
		send_request(rtsc_pkg::OP_RELEASE, 8'd60, 16'h0000);
		drain_results();
	endtask

	task automatic test_count_saturation();
		write_ceiling(16'hFFFF);
		send_request(rtsc_pkg::OP_CLEAR, 8'd0, 16'h0000);
		repeat (260)
			send_request(rtsc_pkg::OP_ACQUIRE, 8'd7, 16'($urandom_range(0, 16'hFFFF)));
		send_request(rtsc_pkg::OP_RELEASE, 8'd7, 16'h0000);
		send_request(rtsc_pkg::OP_RELEASE, 8'd7, 16'h0000);
		send_request(rtsc_pkg::OP_ACQUIRE, 8'd7, 16'h0000);
		for (int i = 0; i < SLOTS - 1; i++)
			send_request(rtsc_pkg::OP_ACQUIRE, 8'(100 + i), 16'h0000);
		// pool is full now, so this id takes the failed path every time
		repeat (260)
			send_request(rtsc_pkg::OP_ACQUIRE, 8'd200, 16'($urandom_range(0, 16'hFFFF)));
		send_request(rtsc_pkg::OP_RELEASE, 8'd200, 16'h0000);
		send_request(rtsc_pkg::OP_CLEAR, 8'd0, 16'h0000);
		drain_results();
	endtask

	task automatic test_random_traffic();
		rtsc_pkg::op_t op;
		logic [7:0] icon;
		logic [15:0] pal;
		int pick;
		int id_span;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_ceiling(16'hFFFF);
				1: write_ceiling(16'h0000);
				3: write_ceiling(rtsc_pkg::CEILING_RESET);
				default: write_ceiling(16'($urandom_range(0, 16'hFFFF)));
			endcase
			calm <= (phase == 2 || phase == 5);
			id_span = (phase % 2 == 0) ? 40 : 55;
			repeat (200) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					op = rtsc_pkg::OP_ACQUIRE;
				else if (pick < 85)
					op = rtsc_pkg::OP_RELEASE;
				else if (pick < 97)
					op = rtsc_pkg::OP_BLANK;
				else
					op = rtsc_pkg::OP_CLEAR;
				pick = $urandom_range(0, 99);
				if (pick < 4)
					icon = 8'($urandom_range(ICONS, 255));
				else if (pick < 75)
					icon = 8'($urandom_range(0, id_span));
				else
					icon = 8'($urandom_range(0, ICONS - 1));
				pick = $urandom_range(0, 9);
				if (pick == 0)
					pal = 16'h0000;
				else if (pick == 1)
					pal = 16'hFFFF;
				else
					pal = 16'($urandom_range(0, 16'hFFFF));
				send_request(op, icon, pal);
			end
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		calm = 1'b0;
		mismatches = 0;
		ceiling_model = rtsc_pkg::CEILING_RESET;
		clear_tables();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_ops();
		test_pool_exhaustion();
		test_count_saturation();
		test_random_traffic();
		if (mismatches == 0 && pending_tiles.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
